/* src/status_led_pattern_sequencer_defines.svh */
// Assertion macros shared by the status LED sequencer RTL.
`ifndef STATUS_LED_PATTERN_SEQUENCER_DEFINES_SVH
`define STATUS_LED_PATTERN_SEQUENCER_DEFINES_SVH

// A property checked on every rising edge of clk, disabled while in reset.
`define SLPS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("slps: assertion failed");

// An implication checked on every rising edge of clk, disabled while in reset.
`define SLPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slps: implication failed");

`endif

/* src/slps_pkg.sv */
// Types, constants and the breathing level table of the status LED sequencer.
`default_nettype none
package slps_pkg;

	localparam int PROCESS_GRACE_MS = 150;
	localparam int BREATH_PERIOD_MS = 1000;
	localparam int BREATH_STEP_MS = 10;
	localparam int BREATH_HALF_MS = BREATH_PERIOD_MS / 2;
	localparam int BREATH_STEPS = BREATH_PERIOD_MS / BREATH_STEP_MS;
	localparam int HALF_STEPS = BREATH_HALF_MS / BREATH_STEP_MS;
	localparam int STEP_W = $clog2(BREATH_STEP_MS);
	localparam int SLOT_W = $clog2(BREATH_STEPS);
	localparam int LUT_W = $clog2(HALF_STEPS + 1);
	localparam longint unsigned LEVEL_FULL = 255;
	localparam longint unsigned BREATH_H3 =
		longint'(BREATH_HALF_MS) * longint'(BREATH_HALF_MS) * longint'(BREATH_HALF_MS);
	localparam longint unsigned BREATH_DEN = 2 * BREATH_H3;

	localparam int CNT_W = 32;
	localparam int IDX_W = $clog2(CNT_W);
	localparam logic [CNT_W-1:0] GRACE_VEC = CNT_W'(PROCESS_GRACE_MS);

	localparam int TIME_W = 12;
	localparam int CYC_W = TIME_W + 1;
	localparam int CFG_W = 8;
	localparam logic [15:0] BURST_TIME_MAX = 16'd4095;
	localparam logic [7:0] LEVEL_ON = 8'd255;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_MODE = 2'd1,
		KIND_BURST = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CLASS_PATTERN = 2'd0,
		CLASS_MOUNTED = 2'd1,
		CLASS_PROCESSING = 2'd2,
		CLASS_PRIORITY = 2'd3
	} class_t;

	typedef enum logic [1:0] {
		REG_FULL_BRIGHT = 2'd0,
		REG_BREATHE_COLOR = 2'd1,
		REG_HIGHEST_COLOR = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_EVAL
	} state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] mode_class;
		logic [11:0] pattern_on_time;
		logic [11:0] pattern_off_time;
		logic [2:0] pattern_color;
		logic [7:0] pattern_brightness;
		logic [7:0] burst_count;
		logic [7:0] burst_color;
		logic [15:0] burst_on_time;
		logic [15:0] burst_off_time;
	} cmd_beat_t;

	typedef struct packed {
		logic lit;
		logic [2:0] shown_color;
		logic [7:0] shown_brightness;
		logic [7:0] shown_level;
	} led_beat_t;

	typedef struct packed {
		logic [1:0] cls;
		logic [TIME_W-1:0] on;
		logic [TIME_W-1:0] off;
		logic [2:0] color;
		logic [7:0] bright;
	} mode_t;

	typedef struct packed {
		logic [7:0] count;
		logic [2:0] color;
		logic [TIME_W-1:0] on;
		logic [TIME_W-1:0] off;
	} burst_t;

	typedef struct packed {
		logic [7:0] level;
		logic [7:0] bright;
		logic [2:0] color;
	} frame_t;

	typedef struct packed {
		logic run;
		logic clear;
		logic [IDX_W-1:0] bit_idx;
	} ser_ctl_t;

	typedef struct packed {
		logic is_zero;
		logic is_one;
		logic below_grace;
	} cnt_flags_t;

	typedef logic [7:0] breath_lut_t [HALF_STEPS+1];

	function automatic breath_lut_t build_breath_lut();
		breath_lut_t lut;
		longint unsigned d;
		longint unsigned num;
		longint unsigned lvl;
		for (int i = 0; i <= HALF_STEPS; i++) begin
			d = longint'(i) * longint'(BREATH_STEP_MS);
			num = 2 * LEVEL_FULL * d * d * (3 * longint'(BREATH_HALF_MS) - 2 * d) + BREATH_H3;
			lvl = num / BREATH_DEN;
			lut[i] = (lvl > LEVEL_FULL) ? LEVEL_ON : lvl[7:0];
		end
		return lut;
	endfunction

	localparam breath_lut_t BREATH_LUT = build_breath_lut();

endpackage
`default_nettype wire

/* src/slps_cmd_if.sv */
// Command channel interface carrying ticks, mode changes and blink requests.
`default_nettype none
interface slps_cmd_if;
	logic valid;
	logic ready;
	slps_pkg::cmd_beat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/slps_led_if.sv */
// LED frame channel interface carrying rendered frames.
`default_nettype none
interface slps_led_if;
	logic valid;
	logic ready;
	slps_pkg::led_beat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/slps_ser_cnt.sv */
// Bit-serial 32-bit millisecond counter with serial compare flags.
`default_nettype none
module slps_ser_cnt (
	input wire logic clk,
	input wire logic arst_n,
	input wire slps_pkg::ser_ctl_t ctl,
	output slps_pkg::cnt_flags_t flags
);

	logic [slps_pkg::CNT_W-1:0] val_q;
	logic carry_q;
	logic zero_q;
	logic one_q;
	logic lt_q;

	logic first;
	logic carry_in;
	logic new_b;
	logic grace_b;
	logic one_b;
	logic zero_prev;
	logic one_prev;
	logic lt_prev;

	always_comb begin
		first = (ctl.bit_idx == '0);
		carry_in = first ? 1'b1 : carry_q;
		new_b = ctl.clear ? 1'b0 : (val_q[0] ^ carry_in);
		grace_b = slps_pkg::GRACE_VEC[ctl.bit_idx];
		one_b = first;
		zero_prev = first ? 1'b1 : zero_q;
		one_prev = first ? 1'b1 : one_q;
		lt_prev = first ? 1'b0 : lt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			carry_q <= 1'b0;
			zero_q <= 1'b0;
			one_q <= 1'b0;
			lt_q <= 1'b0;
		end else if (ctl.run) begin
			val_q <= {new_b, val_q[slps_pkg::CNT_W-1:1]};
			carry_q <= val_q[0] & carry_in;
			zero_q <= zero_prev & ~new_b;
			one_q <= one_prev & (new_b == one_b);
			lt_q <= (~new_b & grace_b) | (~(new_b ^ grace_b) & lt_prev);
		end
	end

	assign flags.is_zero = zero_q;
	assign flags.is_one = one_q;
	assign flags.below_grace = lt_q;

endmodule
`default_nettype wire

/* src/status_led_pattern_sequencer.sv */
// Status LED sequencer top level: command decode, tick sequencing and frame rendering.
// An accepted tick runs a bit-serial update of the millisecond and mode-elapsed counters
// in the COUNT state, then the EVAL state commits it and registers a frame if it changed.
// Commands are accepted only in the idle state: a new tick waits for the serial pass
// and evaluation of the last, and evaluation waits while an earlier frame is still held.
// Mode changes, blink requests and configuration writes are each registered directly.
// Asynchronous active-low reset restores the register defaults and clears all but out_q.
`default_nettype none
`include "status_led_pattern_sequencer_defines.svh"
module status_led_pattern_sequencer (
	input wire logic clk,
	input wire logic arst_n,
	slps_cmd_if.sink cmd,
	slps_led_if.source led,
	input wire logic cfg_write,
	input wire logic [1:0] cfg_index,
	input wire logic [slps_pkg::CFG_W-1:0] cfg_data
);

	slps_pkg::state_t state_q, state_d;
	logic [slps_pkg::IDX_W-1:0] bit_q;

	logic [7:0] full_q;
	logic [2:0] breathe_q;
	logic [2:0] highest_q;

	slps_pkg::mode_t mode_q, prev_q;
	logic prev_known_q;
	logic mchg_q;

	slps_pkg::burst_t pend_q, act_q;
	logic pend_v_q, act_v_q;
	logic [slps_pkg::CYC_W-1:0] pos_q;
	logic [7:0] blink_q;

	logic [slps_pkg::STEP_W-1:0] step_q;
	logic [slps_pkg::SLOT_W-1:0] slot_q;
	logic [slps_pkg::CYC_W-1:0] ph_q;

	slps_pkg::frame_t last_q;
	logic last_v_q;
	logic out_vld_q;
	slps_pkg::led_beat_t out_q;

	logic ready;
	logic run;
	logic commit;
	logic accepted;
	logic burst_ok;

	slps_pkg::ser_ctl_t ms_ctl, me_ctl;
	slps_pkg::cnt_flags_t ms_flags, me_flags;

	logic prio;
	logic activate;
	slps_pkg::burst_t act_sel;
	logic [slps_pkg::CYC_W-1:0] b_cycle;
	logic [slps_pkg::CYC_W-1:0] pos_inc;
	logic [slps_pkg::CYC_W-1:0] pos_n;
	logic [7:0] blink_n;
	logic live;
	logic burst_on;
	logic [slps_pkg::STEP_W-1:0] step_n;
	logic [slps_pkg::SLOT_W-1:0] slot_n;
	logic [slps_pkg::LUT_W-1:0] d_idx;
	logic [slps_pkg::CYC_W-1:0] p_cycle;
	logic [slps_pkg::CYC_W-1:0] ph_inc;
	logic [slps_pkg::CYC_W-1:0] ph_n;
	logic pat_lit;
	logic mounted;
	slps_pkg::frame_t pick;
	slps_pkg::frame_t frame;
	logic changed;

	assign ms_ctl = '{run: run, clear: 1'b0, bit_idx: bit_q};
	assign me_ctl = '{run: run, clear: mchg_q, bit_idx: bit_q};

	slps_ser_cnt u_millis (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ms_ctl),
		.flags(ms_flags)
	);

	slps_ser_cnt u_mode_age (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(me_ctl),
		.flags(me_flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ready = 1'b0;
		run = 1'b0;
		commit = 1'b0;
		case (state_q)
			slps_pkg::ST_IDLE: begin
				ready = 1'b1;
				if (cmd.valid && cmd.data.kind == slps_pkg::KIND_TICK) begin
					state_d = slps_pkg::ST_COUNT;
				end
			end
			slps_pkg::ST_COUNT: begin
				run = 1'b1;
				if (bit_q == '1) begin
					state_d = slps_pkg::ST_EVAL;
				end
			end
			slps_pkg::ST_EVAL: begin
				if (!out_vld_q || led.ready) begin
					commit = 1'b1;
					state_d = slps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = slps_pkg::ST_IDLE;
			end
		endcase
	end

	assign cmd.ready = ready;
	assign accepted = cmd.valid && ready;

	assign burst_ok = (cmd.data.burst_count != 8'd0) &&
		(cmd.data.burst_color <= {5'd0, highest_q}) &&
		(cmd.data.burst_on_time != 16'd0) &&
		(cmd.data.burst_off_time != 16'd0) &&
		(cmd.data.burst_on_time <= slps_pkg::BURST_TIME_MAX) &&
		(cmd.data.burst_off_time <= slps_pkg::BURST_TIME_MAX);

	always_comb begin
		prio = (mode_q.cls == slps_pkg::CLASS_PRIORITY);
		activate = pend_v_q && !prio;
		act_sel = activate ? pend_q : act_q;
		b_cycle = {1'b0, act_sel.on} + {1'b0, act_sel.off};
		pos_inc = pos_q + 1'b1;
		if (activate) begin
			pos_n = '0;
			blink_n = 8'd0;
		end else if (pos_inc == b_cycle) begin
			pos_n = '0;
			blink_n = blink_q + 8'd1;
		end else begin
			pos_n = pos_inc;
			blink_n = blink_q;
		end
		live = (activate || (act_v_q && !prio)) && (blink_n < act_sel.count);
		burst_on = pos_n < {1'b0, act_sel.on};

		if (ms_flags.is_one) begin
			step_n = '0;
			slot_n = '0;
		end else if (step_q == slps_pkg::STEP_W'(slps_pkg::BREATH_STEP_MS - 1)) begin
			step_n = '0;
			slot_n = (slot_q == slps_pkg::SLOT_W'(slps_pkg::BREATH_STEPS - 1)) ?
				'0 : slot_q + 1'b1;
		end else begin
			step_n = step_q + 1'b1;
			slot_n = slot_q;
		end
		if (slot_n >= slps_pkg::SLOT_W'(slps_pkg::HALF_STEPS)) begin
			d_idx = slps_pkg::LUT_W'(slot_n - slps_pkg::SLOT_W'(slps_pkg::HALF_STEPS));
		end else begin
			d_idx = slps_pkg::LUT_W'(slps_pkg::SLOT_W'(slps_pkg::HALF_STEPS) - slot_n);
		end

		p_cycle = {1'b0, mode_q.on} + {1'b0, mode_q.off};
		ph_inc = ph_q + 1'b1;
		if (me_flags.is_zero || ph_inc == p_cycle) begin
			ph_n = '0;
		end else begin
			ph_n = ph_inc;
		end
		pat_lit = (mode_q.on != '0) &&
			((mode_q.off == '0) || (ph_n < {1'b0, mode_q.on}));

		mounted = (mode_q.cls == slps_pkg::CLASS_MOUNTED) ||
			((mode_q.cls == slps_pkg::CLASS_PROCESSING) && me_flags.below_grace);

		if (live) begin
			pick = '{level: burst_on ? slps_pkg::LEVEL_ON : 8'd0,
				bright: full_q, color: act_sel.color};
		end else if (mounted) begin
			pick = '{level: slps_pkg::BREATH_LUT[d_idx], bright: full_q, color: breathe_q};
		end else begin
			pick = '{level: pat_lit ? slps_pkg::LEVEL_ON : 8'd0,
				bright: mode_q.bright, color: mode_q.color};
		end
		frame = (pick.level != 8'd0) ? pick : '0;
		changed = !last_v_q || (frame != last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
			full_q <= 8'd255;
			breathe_q <= 3'd1;
			highest_q <= 3'd7;
			mode_q <= '{cls: slps_pkg::CLASS_PRIORITY, default: '0};
			prev_q <= '0;
			prev_known_q <= 1'b0;
			mchg_q <= 1'b0;
			pend_q <= '0;
			pend_v_q <= 1'b0;
			act_q <= '0;
			act_v_q <= 1'b0;
			pos_q <= '0;
			blink_q <= 8'd0;
			step_q <= '0;
			slot_q <= '0;
			ph_q <= '0;
			last_q <= '0;
			last_v_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (run) begin
				bit_q <= bit_q + 1'b1;
			end

			if (cfg_write) begin
				case (cfg_index)
					slps_pkg::REG_FULL_BRIGHT: full_q <= cfg_data[7:0];
					slps_pkg::REG_BREATHE_COLOR: breathe_q <= cfg_data[2:0];
					slps_pkg::REG_HIGHEST_COLOR: highest_q <= cfg_data[2:0];
					default: begin
					end
				endcase
			end

			if (accepted) begin
				case (cmd.data.kind)
					slps_pkg::KIND_TICK: begin
						mchg_q <= !prev_known_q || (mode_q != prev_q);
						prev_q <= mode_q;
						prev_known_q <= 1'b1;
						bit_q <= '0;
					end
					slps_pkg::KIND_MODE: begin
						mode_q <= '{cls: cmd.data.mode_class,
							on: cmd.data.pattern_on_time,
							off: cmd.data.pattern_off_time,
							color: cmd.data.pattern_color,
							bright: cmd.data.pattern_brightness};
					end
					slps_pkg::KIND_BURST: begin
						if (burst_ok) begin
							pend_v_q <= 1'b1;
							pend_q <= '{count: cmd.data.burst_count,
								color: cmd.data.burst_color[2:0],
								on: cmd.data.burst_on_time[slps_pkg::TIME_W-1:0],
								off: cmd.data.burst_off_time[slps_pkg::TIME_W-1:0]};
						end
					end
					default: begin
					end
				endcase
			end

			if (commit && changed) begin
				out_vld_q <= 1'b1;
			end else if (led.ready) begin
				out_vld_q <= 1'b0;
			end

			if (commit) begin
				pend_v_q <= 1'b0;
				act_q <= act_sel;
				act_v_q <= live;
				pos_q <= pos_n;
				blink_q <= blink_n;
				step_q <= step_n;
				slot_q <= slot_n;
				ph_q <= ph_n;
				if (changed) begin
					last_q <= frame;
					last_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && changed) begin
			out_q <= '{lit: frame.level != 8'd0, shown_color: frame.color,
				shown_brightness: frame.bright, shown_level: frame.level};
		end
	end

	assign led.valid = out_vld_q;
	assign led.data = out_q;

	`SLPS_ASSERT(a_frame_from_eval, $rose(out_vld_q) |-> $past(state_q == slps_pkg::ST_EVAL))
	`SLPS_ASSERT_IMP(a_blink_in_range, act_v_q, blink_q < act_q.count)
	`SLPS_ASSERT(a_breath_range, (step_q < slps_pkg::STEP_W'(slps_pkg::BREATH_STEP_MS)) && (slot_q < slps_pkg::SLOT_W'(slps_pkg::BREATH_STEPS)))
	`SLPS_ASSERT(a_priority_cancels, (commit && mode_q.cls == slps_pkg::CLASS_PRIORITY) |=> (!act_v_q && !pend_v_q))

endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the status LED sequencer: directed table, then random phases.
`default_nettype none
module testbench;
	import slps_pkg::*;

	localparam int LATENCY_CYCLES = 34;
	localparam int DRAIN_CYCLES = 2 * LATENCY_CYCLES;
	localparam int QUIET_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam led_beat_t LED_DARK = '0;

	typedef struct {
		cmd_beat_t beat;
		bit typed;
		led_beat_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	slps_cmd_if cmd_bus();
	slps_led_if led_bus();

	status_led_pattern_sequencer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.led(led_bus),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [7:0] cfg_full_bright = 8'd255;
	logic [2:0] cfg_breathe_color = 3'd1;
	logic [2:0] cfg_highest_color = 3'd7;
	logic [31:0] now_ms = '0;
	mode_t mode_cur = '{cls: CLASS_PRIORITY, default: '0};
	mode_t mode_prev = '0;
	bit mode_prev_known = 1'b0;
	logic [31:0] mode_t0 = '0;
	logic [31:0] breath_t0 = '0;
	bit breath_begun = 1'b0;
	burst_t blink_req = '0;
	bit blink_waiting = 1'b0;
	burst_t blink_run = '0;
	bit blink_running = 1'b0;
	logic [31:0] blink_t0 = '0;
	frame_t frame_last = '0;
	bit frame_known = 1'b0;

	led_beat_t frames_due[$];
	plan_row_t plan_q[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	bit gaps_on = 1'b1;

	function automatic logic [7:0] breath_level_at(input logic [31:0] now);
		logic [31:0] elapsed;
		longint unsigned ph;
		longint unsigned h;
		longint unsigned d;
		longint unsigned num;
		longint unsigned lvl;
		elapsed = now - breath_t0;
		ph = ((elapsed / BREATH_STEP_MS) * BREATH_STEP_MS) % BREATH_PERIOD_MS;
		h = BREATH_PERIOD_MS / 2;
		d = (ph < h) ? h - ph : ph - h;
		num = 2 * 255 * d * d * (3 * h - 2 * d) + h * h * h;
		lvl = num / (2 * h * h * h);
		return (lvl > 255) ? 8'd255 : lvl[7:0];
	endfunction

	function automatic bit predict_led_frame(input cmd_beat_t b, output led_beat_t f);
		class_t cls;
		logic [31:0] elapsed;
		logic [31:0] span;
		logic [2:0] col;
		logic [7:0] br;
		logic [7:0] lvl;
		bit have;
		frame_t fr;
		f = '0;
		case (b.kind)
			KIND_MODE: begin
				mode_cur = '{cls: b.mode_class, on: b.pattern_on_time, off: b.pattern_off_time,
					color: b.pattern_color, bright: b.pattern_brightness};
				return 1'b0;
			end
			KIND_BURST: begin
				if (b.burst_count == 0 || b.burst_color > {5'd0, cfg_highest_color} ||
						b.burst_on_time == 0 || b.burst_off_time == 0 ||
						b.burst_on_time > BURST_TIME_MAX || b.burst_off_time > BURST_TIME_MAX)
					return 1'b0;
				blink_req = '{count: b.burst_count, color: b.burst_color[2:0],
					on: b.burst_on_time[11:0], off: b.burst_off_time[11:0]};
				blink_waiting = 1'b1;
				return 1'b0;
			end
			KIND_TICK: begin
			end
			default: return 1'b0;
		endcase

		now_ms = now_ms + 1;
		if (!breath_begun) begin
			breath_t0 = now_ms;
			breath_begun = 1'b1;
		end
		if (!mode_prev_known || mode_cur != mode_prev) begin
			mode_prev = mode_cur;
			mode_prev_known = 1'b1;
			mode_t0 = now_ms;
		end
		cls = class_t'(mode_cur.cls);
		if (cls == CLASS_PRIORITY) begin
			blink_waiting = 1'b0;
			blink_running = 1'b0;
		end
		if (blink_waiting) begin
			blink_run = blink_req;
			blink_t0 = now_ms;
			blink_running = 1'b1;
			blink_waiting = 1'b0;
		end
		have = 1'b0;
		if (blink_running) begin
			elapsed = now_ms - blink_t0;
			span = 32'(blink_run.on) + 32'(blink_run.off);
			if (elapsed / span < 32'(blink_run.count)) begin
				col = blink_run.color;
				br = cfg_full_bright;
				lvl = (elapsed % span < 32'(blink_run.on)) ? 8'd255 : 8'd0;
				have = 1'b1;
			end else begin
				blink_running = 1'b0;
			end
		end
		if (!have) begin
			if (cls == CLASS_PROCESSING && now_ms - mode_t0 < PROCESS_GRACE_MS)
				cls = CLASS_MOUNTED;
			if (cls == CLASS_MOUNTED) begin
				col = cfg_breathe_color;
				br = cfg_full_bright;
				lvl = breath_level_at(now_ms);
			end else begin
				col = mode_cur.color;
				br = mode_cur.bright;
				span = 32'(mode_cur.on) + 32'(mode_cur.off);
				lvl = (mode_cur.on != 0 && (mode_cur.off == 0 ||
					(now_ms - mode_t0) % span < 32'(mode_cur.on))) ? 8'd255 : 8'd0;
			end
		end

		fr = (lvl != 0) ? '{level: lvl, bright: br, color: col} : '0;
		if (frame_known && fr == frame_last)
			return 1'b0;
		frame_known = 1'b1;
		frame_last = fr;
		f.lit = (lvl != 0);
		f.shown_color = f.lit ? col : 3'd0;
		f.shown_brightness = f.lit ? br : 8'd0;
		f.shown_level = lvl;
		return 1'b1;
	endfunction

	function automatic cmd_beat_t scrambled();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return raw[$bits(cmd_beat_t)-1:0];
	endfunction

	function automatic cmd_beat_t tick_beat();
		cmd_beat_t b;
		b = scrambled();
		b.kind = KIND_TICK;
		return b;
	endfunction

	function automatic cmd_beat_t mode_beat(input class_t c, input logic [11:0] on,
			input logic [11:0] off, input logic [2:0] col, input logic [7:0] br);
		cmd_beat_t b;
		b = scrambled();
		b.kind = KIND_MODE;
		b.mode_class = c;
		b.pattern_on_time = on;
		b.pattern_off_time = off;
		b.pattern_color = col;
		b.pattern_brightness = br;
		return b;
	endfunction

	function automatic cmd_beat_t blink_beat(input logic [7:0] n, input logic [7:0] col,
			input logic [15:0] on, input logic [15:0] off);
		cmd_beat_t b;
		b = scrambled();
		b.kind = KIND_BURST;
		b.burst_count = n;
		b.burst_color = col;
		b.burst_on_time = on;
		b.burst_off_time = off;
		return b;
	endfunction

	function automatic logic [11:0] mode_span();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick < 2)
			return 12'd0;
		if (pick == 2)
			return 12'($urandom);
		return 12'($urandom_range(1, 30));
	endfunction

	function automatic void plan(input cmd_beat_t b, input bit typed = 1'b0,
			input led_beat_t want = '0);
		plan_q.push_back('{beat: b, typed: typed, want: want});
	endfunction

	task automatic push_cmd(input cmd_beat_t b, input bit typed, input led_beat_t want);
		led_beat_t f;
		bit hit;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			cmd_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.data <= b;
		do @(posedge clk); while (!cmd_bus.ready);
		hit = predict_led_frame(b, f);
		if (typed)
			frames_due.push_back(want);
		else if (hit)
			frames_due.push_back(f);
		@(negedge clk);
	endtask

	task automatic settle();
		cmd_bus.valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [7:0] full, input logic [2:0] breathe,
			input logic [2:0] highest);
		logic [1:0] idx [4];
		logic [7:0] val [4];
		idx = '{REG_FULL_BRIGHT, REG_BREATHE_COLOR, REG_HIGHEST_COLOR, REG_SPARE};
		val = '{full, {5'($urandom), breathe}, {5'($urandom), highest}, 8'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(negedge clk);
		end
		cfg_write <= 1'b0;
		cfg_full_bright = full;
		cfg_breathe_color = breathe;
		cfg_highest_color = highest;
	endtask

	task automatic run_random(input int count, input int mode_pct, input int blink_pct);
		int done_items;
		int r;
		int why;
		cmd_beat_t b;
		logic [7:0] n;
		logic [15:0] on;
		logic [15:0] off;
		done_items = 0;
		while (done_items < count) begin
			r = $urandom_range(0, 99);
			if (r < mode_pct) begin
				b = mode_beat(class_t'($urandom_range(0, 3)), mode_span(), mode_span(),
					3'($urandom), 8'($urandom));
				done_items++;
			end else if (r < mode_pct + blink_pct + 4) begin
				n = 8'($urandom_range(1, 3));
				on = 16'($urandom_range(1, 6));
				off = 16'($urandom_range(1, 6));
				if ($urandom_range(0, 19) == 0)
					n = 8'($urandom_range(1, 255));
				else if ($urandom_range(0, 15) == 0) begin
					n = 8'd1;
					on = 16'($urandom_range(1, 4095));
					off = 16'($urandom_range(1, 4095));
				end
				b = blink_beat(n, 8'($urandom_range(0, cfg_highest_color)), on, off);
				if (r < mode_pct + blink_pct) begin
					done_items++;
				end else begin
					why = $urandom_range(0, 5);
					case (why)
						0: b.burst_count = 8'd0;
						1: b.burst_color = 8'($urandom_range(32'(cfg_highest_color) + 1, 255));
						2: b.burst_on_time = 16'd0;
						3: b.burst_off_time = 16'd0;
						4: b.burst_on_time = 16'($urandom_range(4096, 65535));
						default: b.burst_off_time = 16'($urandom_range(4096, 65535));
					endcase
					if ($urandom_range(0, 3) == 0)
						b.kind = KIND_UNKNOWN;
				end
			end else begin
				b = tick_beat();
				done_items++;
			end
			push_cmd(b, 1'b0, LED_DARK);
		end
	endtask

	initial begin
		led_bus.ready = 1'b0;
		forever begin : ready_drive
			int stall_left;
			@(negedge clk);
			if (stall_left > 0) begin
				led_bus.ready <= 1'b0;
				stall_left--;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				led_bus.ready <= 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				led_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		led_beat_t want;
		if (arst_n && led_bus.valid && led_bus.ready) begin
			if (frames_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected LED frame: lit %0d color %0d bright %0d level %0d",
						led_bus.data.lit, led_bus.data.shown_color,
						led_bus.data.shown_brightness, led_bus.data.shown_level);
			end else begin
				want = frames_due.pop_front();
				if (led_bus.data.lit !== want.lit ||
						led_bus.data.shown_color !== want.shown_color ||
						led_bus.data.shown_brightness !== want.shown_brightness ||
						led_bus.data.shown_level !== want.shown_level) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("LED frame mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							want.lit, want.shown_color, want.shown_brightness,
							want.shown_level, led_bus.data.lit, led_bus.data.shown_color,
							led_bus.data.shown_brightness, led_bus.data.shown_level);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_bus.valid && cmd_bus.ready) || (led_bus.valid && led_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.data = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		// The first tick after reset always renders, and priority mode with zero times is dark.
		plan(tick_beat(), 1'b1, LED_DARK);
		plan(tick_beat());
		plan(mode_beat(CLASS_PATTERN, 12'd4095, 12'd0, 3'd7, 8'd255));
		plan(tick_beat(), 1'b1, '{lit: 1'b1, shown_color: 3'd7, shown_brightness: 8'd255,
			shown_level: 8'd255});
		plan(mode_beat(CLASS_PATTERN, 12'd1, 12'd1, 3'd3, 8'd0));
		plan(tick_beat(), 1'b1, '{lit: 1'b1, shown_color: 3'd3, shown_brightness: 8'd0,
			shown_level: 8'd255});
		plan(tick_beat(), 1'b1, LED_DARK);
		plan(blink_beat(8'd0, 8'd1, 16'd5, 16'd5));
		plan(blink_beat(8'd1, 8'd255, 16'd5, 16'd5));
		plan(blink_beat(8'd255, 8'd2, 16'd0, 16'd5));
		plan(blink_beat(8'd1, 8'd2, 16'd5, 16'd4096));
		plan(blink_beat(8'd1, 8'd2, 16'd65535, 16'd65535));
		plan(blink_beat(8'd2, 8'd5, 16'd2, 16'd1));
		plan(tick_beat(), 1'b1, '{lit: 1'b1, shown_color: 3'd5, shown_brightness: 8'd255,
			shown_level: 8'd255});
		repeat (6) plan(tick_beat());
		plan(mode_beat(CLASS_MOUNTED, 12'd0, 12'd0, 3'd0, 8'd0));
		plan(tick_beat());
		plan(mode_beat(CLASS_PROCESSING, 12'd0, 12'd0, 3'd0, 8'd0));
		plan(tick_beat());
		plan(blink_beat(8'd3, 8'd7, 16'd4095, 16'd4095));
		plan(mode_beat(CLASS_PRIORITY, 12'd0, 12'd0, 3'd0, 8'd0));
		plan(tick_beat());
		begin : odd_kind
			cmd_beat_t b;
			b = scrambled();
			b.kind = KIND_UNKNOWN;
			plan(b);
		end
		plan(tick_beat());

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan_q[i])
			push_cmd(plan_q[i].beat, plan_q[i].typed, plan_q[i].want);
		settle();

		program_regs(8'd255, 3'd1, 3'd7);
		run_random(300, 8, 8);
		settle();

		// Rare mode changes let the processing grace run out and breathing sweep its ramp.
		program_regs(8'd0, 3'd0, 3'd0);
		run_random(500, 1, 2);
		settle();

		program_regs(8'($urandom), 3'($urandom), 3'($urandom));
		run_random(300, 5, 10);
		settle();

		gaps_on = 1'b0;
		program_regs(8'd128, 3'd7, 3'd7);
		run_random(300, 3, 5);
		settle();

		if (mismatch_count == 0 && frames_due.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
